>>> rtl/kts_pkg.sv
// Shared types and constants for the keyframe time sampler.
// No dependencies; every other file imports this package.
package kts_pkg;

   localparam int TIME_W           = 32;
   localparam int FRAC_BITS        = 16;
   localparam int FRAME_INDEX_BITS = 16;
   localparam int BLEND_W          = FRAC_BITS + 1;
   localparam int WRAP_STEPS       = TIME_W;
   localparam int INDEX_STEPS      = TIME_W;
   localparam int BLEND_STEPS      = FRAC_BITS;

   typedef enum logic [1:0] {
      WRAP_CLAMP    = 2'd0,
      WRAP_LOOP     = 2'd1,
      WRAP_PINGPONG = 2'd2,
      WRAP_NONE     = 2'd3
   } wrap_mode_type;

   typedef enum logic [1:0] {
      CSR_WRAP_MODE    = 2'd0,
      CSR_CLIP_LENGTH  = 2'd1,
      CSR_FRAME_PERIOD = 2'd2,
      CSR_FRAME_TOTAL  = 2'd3
   } csr_index_type;

   typedef struct packed {
      wrap_mode_type                wrap_mode;
      logic [TIME_W-1:0]           clip_length;
      logic [TIME_W-1:0]           frame_period;
      logic [FRAME_INDEX_BITS-1:0] frame_total;
   } cfg_type;

   // Classified item: the wrap is a remainder by divisor, then an optional reflect.
   typedef struct packed {
      logic              reflect;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W:0]   divisor;
   } front_item_type;

endpackage

>>> rtl/keyframe_time_sampler_top.sv
// Top level of the keyframe time sampler: configuration registers and the
// front, queue and back parts. Depends on kts_pkg, kts_front, kts_queue, kts_back.
//
// Use: write wrap_mode, clip_length, frame_period and frame_total through the
// csr_ channel (always ready) while no sample is in flight. Send one playback
// time per req_ transaction; each yields exactly one rsp_ transaction with the
// two keyframe indices and the Q1.16 weight of the later one, in order.
// Throughput is one transaction per cycle while the receiver does not stall.
// From acceptance to response valid a request passes one front register, one
// queue slot, 32 wrap remainder stages, one reflect stage, 32 frame-index
// divide stages, one multiply stage, one span select stage and 16 blend stages.
// When the receiver stalls, the back pipeline holds as a whole; the queue and
// front register absorb up to three more requests before req_ready drops.
// Reset is synchronous and empties the pipeline and queue and loads the
// default clip: clamp, length 1.0 s, period 2185/65536 s, 31 frames.
module keyframe_time_sampler_top import kts_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [TIME_W-1:0]             csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TIME_W-1:0]             req_play_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [FRAME_INDEX_BITS-1:0]  rsp_first_frame,
   output logic [FRAME_INDEX_BITS-1:0]  rsp_second_frame,
   output logic [BLEND_W-1:0]           rsp_blend_weight
);

   wrap_mode_type               wrap_mode_ff;
   logic [TIME_W-1:0]           clip_length_ff;
   logic [TIME_W-1:0]           frame_period_ff;
   logic [FRAME_INDEX_BITS-1:0] frame_total_ff;
   cfg_type                     cfg;

   logic           front_valid, front_ready;
   front_item_type front_item;
   logic           back_valid, back_ready;
   front_item_type back_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_mode_ff    <= WRAP_CLAMP;
         clip_length_ff  <= TIME_W'(65536);
         frame_period_ff <= TIME_W'(2185);
         frame_total_ff  <= FRAME_INDEX_BITS'(31);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_WRAP_MODE:    wrap_mode_ff    <= wrap_mode_type'(csr_data[1:0]);
            CSR_CLIP_LENGTH:  clip_length_ff  <= csr_data;
            CSR_FRAME_PERIOD: frame_period_ff <= csr_data;
            CSR_FRAME_TOTAL:  frame_total_ff  <= csr_data[FRAME_INDEX_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.wrap_mode    = wrap_mode_ff;
   assign cfg.clip_length  = clip_length_ff;
   assign cfg.frame_period = frame_period_ff;
   assign cfg.frame_total  = frame_total_ff;

   kts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_play_time (req_play_time),
      .item_valid    (front_valid),
      .item_ready    (front_ready),
      .item          (front_item)
   );

   kts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   kts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_valid       (back_valid),
      .item_ready       (back_ready),
      .item             (back_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_frame  (rsp_first_frame),
      .rsp_second_frame (rsp_second_frame),
      .rsp_blend_weight (rsp_blend_weight)
   );

endmodule

>>> rtl/kts_front.sv
// Front end: input register and wrap-mode classification.
// Depends on kts_pkg.
module kts_front import kts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TIME_W-1:0]   req_play_time,
   output logic                item_valid,
   input  logic                item_ready,
   output front_item_type      item
);

   logic           valid_ff, valid_in;
   front_item_type item_ff, item_in;
   logic           len_zero;

   assign len_zero = (cfg.clip_length == '0);

   always_comb begin
      item_in.reflect  = 1'b0;
      item_in.dividend = req_play_time;
      item_in.divisor  = '1;
      case (cfg.wrap_mode)
         WRAP_CLAMP: begin
            item_in.dividend = (req_play_time > cfg.clip_length) ? cfg.clip_length
                                                                 : req_play_time;
         end
         WRAP_LOOP: begin
            if (len_zero) item_in.dividend = '0;
            else          item_in.divisor  = {1'b0, cfg.clip_length};
         end
         WRAP_PINGPONG: begin
            if (len_zero) begin
               item_in.dividend = '0;
            end else begin
               item_in.divisor = {cfg.clip_length, 1'b0};
               item_in.reflect = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign valid_in   = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= item_in;
   end

endmodule

>>> rtl/kts_queue.sv
// Two-entry queue between front and back end.
// Depends on kts_pkg.
module kts_queue import kts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  front_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output front_item_type pop_item
);

   front_item_type store_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff, count_in;
   logic           push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");

endmodule

>>> rtl/kts_back.sv
// Back end: wrap remainder, reflect, frame index divide, multiply, span select
// and blend divide, one compare-subtract per divide stage. Depends on kts_pkg.
module kts_back import kts_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  front_item_type                item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [FRAME_INDEX_BITS-1:0]  rsp_first_frame,
   output logic [FRAME_INDEX_BITS-1:0]  rsp_second_frame,
   output logic [BLEND_W-1:0]           rsp_blend_weight
);

   typedef struct packed {
      logic              reflect;
      logic [TIME_W-1:0] dividend;
      logic [TIME_W:0]   rem;
      logic [TIME_W:0]   divisor;
   } wrap_stage_type;

   typedef struct packed {
      logic [TIME_W-1:0] quot;
      logic [TIME_W-1:0] rem;
   } index_stage_type;

   typedef struct packed {
      logic                          last;
      logic                          part;
      logic [FRAME_INDEX_BITS-1:0]  idx;
      logic [TIME_W-1:0]            rem;
      logic [TIME_W+FRAME_INDEX_BITS-1:0] used;
   } span_stage_type;

   typedef struct packed {
      logic                          last;
      logic                          zero;
      logic                          sat;
      logic [FRAME_INDEX_BITS-1:0]  idx;
      logic [TIME_W-1:0]            rem;
      logic [TIME_W-1:0]            divisor;
      logic [FRAC_BITS-1:0]         quot;
   } blend_stage_type;

   function automatic wrap_stage_type wrap_step(wrap_stage_type x);
      logic [TIME_W+1:0] r2;
      logic [TIME_W+1:0] diff;
      logic              ge;
      wrap_stage_type    y;
      r2   = {x.rem, x.dividend[TIME_W-1]};
      diff = r2 - {1'b0, x.divisor};
      ge   = (r2 >= {1'b0, x.divisor});
      y          = x;
      y.dividend = {x.dividend[TIME_W-2:0], 1'b0};
      y.rem      = ge ? diff[TIME_W:0] : r2[TIME_W:0];
      return y;
   endfunction

   function automatic index_stage_type index_step(index_stage_type x,
                                                  logic [TIME_W-1:0] p);
      logic [TIME_W:0] r2;
      logic [TIME_W:0] diff;
      logic            ge;
      index_stage_type y;
      r2     = {x.rem, x.quot[TIME_W-1]};
      diff   = r2 - {1'b0, p};
      ge     = (r2 >= {1'b0, p});
      y.quot = {x.quot[TIME_W-2:0], ge};
      y.rem  = ge ? diff[TIME_W-1:0] : r2[TIME_W-1:0];
      return y;
   endfunction

   function automatic blend_stage_type blend_step(blend_stage_type x);
      logic [TIME_W:0] r2;
      logic [TIME_W:0] diff;
      logic            ge;
      blend_stage_type y;
      r2     = {x.rem, 1'b0};
      diff   = r2 - {1'b0, x.divisor};
      ge     = (r2 >= {1'b0, x.divisor});
      y      = x;
      y.quot = {x.quot[FRAC_BITS-2:0], ge};
      y.rem  = ge ? diff[TIME_W-1:0] : r2[TIME_W-1:0];
      return y;
   endfunction

   logic adv;

   wrap_stage_type  wrap_ff  [WRAP_STEPS];
   wrap_stage_type  wrap_src [WRAP_STEPS];
   logic [WRAP_STEPS-1:0] wrap_v_ff;

   logic              time_v_ff;
   logic [TIME_W-1:0] time_ff, time_in;

   index_stage_type index_ff  [INDEX_STEPS];
   index_stage_type index_src [INDEX_STEPS];
   logic [INDEX_STEPS-1:0] index_v_ff;

   logic           span_v_ff;
   span_stage_type span_ff, span_in;

   logic            sel_v_ff;
   blend_stage_type sel_ff, sel_in;

   blend_stage_type blend_ff  [BLEND_STEPS];
   blend_stage_type blend_src [BLEND_STEPS];
   logic [BLEND_STEPS-1:0] blend_v_ff;

   logic [FRAME_INDEX_BITS-1:0] frames, last_frame;
   index_stage_type             idx_done;
   blend_stage_type             out_stage;

   // the whole pipeline moves as one; hold everything while the output waits
   assign adv        = !rsp_valid || rsp_ready;
   assign item_ready = adv;

   assign frames     = (cfg.frame_total == '0) ? FRAME_INDEX_BITS'(1) : cfg.frame_total;
   assign last_frame = frames - FRAME_INDEX_BITS'(1);

   // wrap remainder
   always_comb begin
      wrap_src[0].reflect  = item.reflect;
      wrap_src[0].dividend = item.dividend;
      wrap_src[0].rem      = '0;
      wrap_src[0].divisor  = item.divisor;
      for (int s = 1; s < WRAP_STEPS; s++) wrap_src[s] = wrap_ff[s-1];
   end

   // reflect past the length: 2L - r, since r - L is r mod L here
   always_comb begin
      logic [TIME_W:0] mirrored;
      mirrored = wrap_ff[WRAP_STEPS-1].divisor - wrap_ff[WRAP_STEPS-1].rem;
      if (wrap_ff[WRAP_STEPS-1].reflect &&
          wrap_ff[WRAP_STEPS-1].rem > {1'b0, cfg.clip_length})
         time_in = mirrored[TIME_W-1:0];
      else
         time_in = wrap_ff[WRAP_STEPS-1].rem[TIME_W-1:0];
   end

   // frame index and remainder
   always_comb begin
      index_src[0].quot = time_ff;
      index_src[0].rem  = '0;
      for (int s = 1; s < INDEX_STEPS; s++) index_src[s] = index_ff[s-1];
   end

   assign idx_done = index_ff[INDEX_STEPS-1];

   // a zero period yields an all-ones quotient, which lands on the last frame
   always_comb begin
      span_in.last = (idx_done.quot >= {{(TIME_W-FRAME_INDEX_BITS){1'b0}}, last_frame});
      span_in.part = (idx_done.quot + TIME_W'(1) ==
                      {{(TIME_W-FRAME_INDEX_BITS){1'b0}}, last_frame});
      span_in.idx  = idx_done.quot[FRAME_INDEX_BITS-1:0];
      span_in.rem  = idx_done.rem;
      span_in.used = (TIME_W+FRAME_INDEX_BITS)'(cfg.frame_period) *
                     (TIME_W+FRAME_INDEX_BITS)'(idx_done.quot[FRAME_INDEX_BITS-1:0]);
   end

   always_comb begin
      logic [TIME_W+FRAME_INDEX_BITS-1:0] remain;
      remain       = {{FRAME_INDEX_BITS{1'b0}}, cfg.clip_length} - span_ff.used;
      sel_in.last  = span_ff.last;
      sel_in.zero  = span_ff.part &&
                     ({{FRAME_INDEX_BITS{1'b0}}, cfg.clip_length} <= span_ff.used);
      sel_in.idx   = span_ff.idx;
      sel_in.rem   = span_ff.rem;
      sel_in.divisor = span_ff.part ? remain[TIME_W-1:0] : cfg.frame_period;
      sel_in.sat   = (span_ff.rem >= sel_in.divisor);
      sel_in.quot  = '0;
   end

   always_comb begin
      blend_src[0] = sel_ff;
      for (int s = 1; s < BLEND_STEPS; s++) blend_src[s] = blend_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_v_ff  <= '0;
         time_v_ff  <= 1'b0;
         index_v_ff <= '0;
         span_v_ff  <= 1'b0;
         sel_v_ff   <= 1'b0;
         blend_v_ff <= '0;
      end else if (adv) begin
         wrap_v_ff  <= {wrap_v_ff[WRAP_STEPS-2:0], item_valid};
         time_v_ff  <= wrap_v_ff[WRAP_STEPS-1];
         index_v_ff <= {index_v_ff[INDEX_STEPS-2:0], time_v_ff};
         span_v_ff  <= index_v_ff[INDEX_STEPS-1];
         sel_v_ff   <= span_v_ff;
         blend_v_ff <= {blend_v_ff[BLEND_STEPS-2:0], sel_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < WRAP_STEPS; s++)  wrap_ff[s]  <= wrap_step(wrap_src[s]);
         time_ff <= time_in;
         for (int s = 0; s < INDEX_STEPS; s++)
            index_ff[s] <= index_step(index_src[s], cfg.frame_period);
         span_ff <= span_in;
         sel_ff  <= sel_in;
         for (int s = 0; s < BLEND_STEPS; s++) blend_ff[s] <= blend_step(blend_src[s]);
      end
   end

   assign out_stage        = blend_ff[BLEND_STEPS-1];
   assign rsp_valid        = blend_v_ff[BLEND_STEPS-1];
   assign rsp_first_frame  = out_stage.last ? last_frame : out_stage.idx;
   assign rsp_second_frame = out_stage.last ? last_frame
                                            : out_stage.idx + FRAME_INDEX_BITS'(1);

   always_comb begin
      if (out_stage.last || out_stage.zero) rsp_blend_weight = '0;
      else if (out_stage.sat)               rsp_blend_weight = BLEND_W'(1) << FRAC_BITS;
      else                                  rsp_blend_weight = {1'b0, out_stage.quot};
   end

   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blend_weight <= (BLEND_W'(1) << FRAC_BITS))
      else $error("blend weight above one");
   a_last_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_stage.last |-> rsp_first_frame == rsp_second_frame &&
                                      rsp_blend_weight == '0)
      else $error("last frame result inconsistent");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(blend_v_ff) && $stable(index_v_ff))
      else $error("pipeline moved while stalled");

endmodule

>>> sim/keyframe_time_sampler_top_test.sv
// Testbench for keyframe_time_sampler_top: directed and random playback times
// across clamp, loop and ping-pong clips, checked against an in-bench predictor.
// Depends on kts_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module keyframe_time_sampler_top_test;
   import kts_pkg::*;

   localparam int LIMIT_CYCLES = 600000;

   typedef struct {
      logic [FRAME_INDEX_BITS-1:0] first_frame;
      logic [FRAME_INDEX_BITS-1:0] second_frame;
      logic [BLEND_W-1:0]          blend_weight;
   } frame_pick_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [1:0]                  csr_index = '0;
   logic [TIME_W-1:0]           csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [TIME_W-1:0]           req_play_time = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [FRAME_INDEX_BITS-1:0] rsp_first_frame;
   logic [FRAME_INDEX_BITS-1:0] rsp_second_frame;
   logic [BLEND_W-1:0]          rsp_blend_weight;

   // clip settings as the block should hold them
   wrap_mode_type               clip_mode;
   logic [TIME_W-1:0]           clip_len;
   logic [TIME_W-1:0]           clip_period;
   logic [FRAME_INDEX_BITS-1:0] clip_frames;

   frame_pick_type pending_picks[$];
   int          err_count = 0;
   int          times_sent = 0;
   int          picks_checked = 0;
   int          clip_settings = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   int          hold_left = 0;

   keyframe_time_sampler_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_play_time    (req_play_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_frame  (rsp_first_frame),
      .rsp_second_frame (rsp_second_frame),
      .rsp_blend_weight (rsp_blend_weight)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_picks.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic frame_pick_type pick_frames(logic [TIME_W-1:0] play);
      longint unsigned t, len, dbl, p, f, idx, rem, used, span, bl;
      frame_pick_type  r;
      t   = play;
      len = clip_len;
      case (clip_mode)
         WRAP_CLAMP: begin
            if (t > len) t = len;
         end
         WRAP_LOOP: begin
            t = (len == 0) ? 0 : t % len;
         end
         WRAP_PINGPONG: begin
            if (len == 0) begin
               t = 0;
            end else begin
               dbl = len * 2;
               t = t % dbl;
               // reflect on the way back, but not exactly at the length
               if (t > len) t = len - (t % len);
            end
         end
         default: ;
      endcase
      p = clip_period;
      f = (clip_frames == 0) ? 1 : clip_frames;
      if (p == 0) begin
         idx = '1;
         rem = 0;
      end else begin
         idx = t / p;
         rem = t % p;
      end
      if (idx >= f - 1) begin
         r.first_frame  = FRAME_INDEX_BITS'(f - 1);
         r.second_frame = FRAME_INDEX_BITS'(f - 1);
         bl = 0;
      end else if (idx == f - 2) begin
         // last partial frame: weight over the remaining span
         used = p * idx;
         r.first_frame  = FRAME_INDEX_BITS'(idx);
         r.second_frame = FRAME_INDEX_BITS'(idx + 1);
         if (clip_len <= used) begin
            bl = 0;
         end else begin
            span = clip_len - used;
            bl = (rem << FRAC_BITS) / span;
            if (bl > (64'd1 << FRAC_BITS)) bl = 64'd1 << FRAC_BITS;
         end
      end else begin
         r.first_frame  = FRAME_INDEX_BITS'(idx);
         r.second_frame = FRAME_INDEX_BITS'(idx + 1);
         bl = (rem << FRAC_BITS) / p;
      end
      r.blend_weight = BLEND_W'(bl);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      err_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      frame_pick_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_first_frame, -1);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_first_frame !== want.first_frame)
               report_mismatch("first_frame", rsp_first_frame, want.first_frame);
            if (rsp_second_frame !== want.second_frame)
               report_mismatch("second_frame", rsp_second_frame, want.second_frame);
            if (rsp_blend_weight !== want.blend_weight)
               report_mismatch("blend_weight", rsp_blend_weight, want.blend_weight);
            picks_checked++;
         end
      end
   end

   // receiver: long hold-offs on request, otherwise a stall pattern of its own
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!stalls_on) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ((cycle_count % 37) < 29) && ($urandom_range(0, 4) != 0);
      end
   end

   task automatic send_time(logic [TIME_W-1:0] play);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid     <= 1'b1;
      req_play_time <= play;
      do @(posedge clock); while (!req_ready);
      pending_picks.push_back(pick_frames(play));
      times_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WRAP_MODE:    clip_mode   = wrap_mode_type'(value[1:0]);
         CSR_CLIP_LENGTH:  clip_len    = value;
         CSR_FRAME_PERIOD: clip_period = value;
         default:          clip_frames = value[FRAME_INDEX_BITS-1:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_clip(wrap_mode_type mode, logic [TIME_W-1:0] len,
                           logic [TIME_W-1:0] period, logic [FRAME_INDEX_BITS-1:0] frames);
      drain_results();
      write_reg(CSR_WRAP_MODE, mode);
      write_reg(CSR_CLIP_LENGTH, len);
      write_reg(CSR_FRAME_PERIOD, period);
      write_reg(CSR_FRAME_TOTAL, frames);
      clip_settings++;
   endtask

   // times near the clip and frame boundaries, plus fully random ones
   function automatic logic [TIME_W-1:0] pick_play_time();
      longint unsigned v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom();
         2:    v = $urandom_range(0, clip_len);
         3:    v = longint'(clip_len) * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
         4:    v = longint'(clip_period) * $urandom_range(0, clip_frames) + $urandom_range(0, 2);
         default: v = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF : 64'd0;
      endcase
      return v[TIME_W-1:0];
   endfunction

   task automatic test_reset_clip();
      clip_mode   = WRAP_CLAMP;
      clip_len    = 32'd65536;
      clip_period = 32'd2185;
      clip_frames = 16'd31;
      send_time(32'd0);
      send_time(32'd2185 * 29 + 100);
      send_time(32'd2185 * 30 - 1);
      send_time(32'd65536);
      send_time(32'hFFFF_FFFF);
   endtask

   task automatic test_directed_cases();
      // last partial frame: full span, start of the span, and zero span
      set_clip(WRAP_CLAMP, 32'd9, 32'd4, 16'd4);
      send_time(32'd9);
      send_time(32'd8);
      set_clip(WRAP_CLAMP, 32'd8, 32'd4, 16'd4);
      send_time(32'd8);
      send_time(32'd5);
      // ping-pong at the length, just past it, at and just under twice it and at the top
      set_clip(WRAP_PINGPONG, 32'd1000, 32'd100, 16'd11);
      send_time(32'd1000);
      send_time(32'd1001);
      send_time(32'd2000);
      send_time(32'd1999);
      send_time(32'hFFFF_FFFF);
      set_clip(WRAP_LOOP, 32'd1000, 32'd100, 16'd11);
      send_time(32'd1000);
      send_time(32'd999);
      send_time(32'hFFFF_FFFF);
      // single frame, then widest values
      set_clip(WRAP_LOOP, 32'hFFFF_FFFF, 32'd1, 16'd1);
      send_time(32'hFFFF_FFFE);
      set_clip(WRAP_PINGPONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd2);
      send_time(32'hFFFF_FFFE);
      send_time(32'h8000_0000);
      set_clip(WRAP_CLAMP, 32'd1, 32'd1, 16'hFFFF);
      send_time(32'd1);
      send_time(32'd0);
      set_clip(WRAP_LOOP, 32'hFFFF_FFFF, 32'h0001_0000, 16'hFFFF);
      send_time(32'hFFFE_FFFF);
      send_time(32'h1234_5678);
   endtask

   task automatic test_random_clips(int total);
      int                          sent;
      int                          per_clip;
      logic [TIME_W-1:0]           period;
      logic [FRAME_INDEX_BITS-1:0] frames;
      longint unsigned             len;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 5))
            0:       period = $urandom();
            1:       period = ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF;
            default: period = $urandom_range(1, 5000);
         endcase
         case ($urandom_range(0, 5))
            0:       frames = FRAME_INDEX_BITS'($urandom_range(1, 2));
            1:       frames = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                          : FRAME_INDEX_BITS'($urandom());
            default: frames = FRAME_INDEX_BITS'($urandom_range(3, 64));
         endcase
         case ($urandom_range(0, 4))
            0:       len = $urandom();
            1:       len = ($urandom_range(0, 1) != 0) ? 64'd1 : 64'hFFFF_FFFF;
            default: len = longint'(period) * (frames - 1) + $urandom_range(0, period);
         endcase
         if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
         if (len == 0) len = 1;
         set_clip(wrap_mode_type'($urandom_range(0, 2)), len[TIME_W-1:0], period, frames);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         per_clip = $urandom_range(20, 80);
         for (int i = 0; i < per_clip; i++) send_time(pick_play_time());
         sent += per_clip;
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_clip(WRAP_PINGPONG, 32'd50000, 32'd700, 16'd80);
      gaps_on = 1'b0;
      // hold the receiver off long enough that the pipeline fills and stalls
      hold_left = 300;
      for (int i = 0; i < 150; i++) send_time(pick_play_time());
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 20; i++) send_time(pick_play_time());
      drain_results();
      for (int i = 0; i < 20; i++) send_time(pick_play_time());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_clip();
      test_directed_cases();
      test_backpressure();
      test_drain_pause();
      test_random_clips(1330);
      drain_results();
      repeat (100) @(posedge clock);
      $display("covered %0d playback times over %0d clip settings, %0d results checked",
               times_sent, clip_settings, picks_checked);
      if (err_count == 0 && pending_picks.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", err_count, pending_picks.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
